### rtl/pis_pkg.sv
// ----------------------------------------------------------------------------
// pis_pkg: shared types and constants for the powerline interference subtractor
// Holds the operation codes, the cell control struct, fixed port widths and
// the base-16 divide-by-five digit step used by the rounding unit.
// ----------------------------------------------------------------------------
package pis_pkg;

  // Fixed widths of the word fields and the threshold register
  localparam int OUT_W = 26;
  localparam int THR_W = 24;

  // Mains period in samples and number of past samples kept
  localparam int PERIOD = 5;
  localparam int NTAP   = 6;

  // Threshold after reset, run counter limits
  localparam logic [THR_W-1:0] THR_RESET = 24'd3000;
  localparam logic [2:0]       RUN_MIN   = 3'd1;
  localparam logic [2:0]       RUN_MAX   = 3'd5;

  // Operation codes of an input word
  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  // Control shared by every state cell in a row
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // One base-16 digit of a divide by five: {quotient digit, remainder}
  function automatic logic [6:0] div5_digit(input logic [2:0] rem, input logic [3:0] dig);
    logic [6:0] n;
    logic [3:0] q;
    logic [2:0] r;
    n = {rem, dig};
    q = 4'd0;
    for (int k = 1; k < 16; k++) begin
      q = q + 4'(n >= 7'(5 * k));
    end
    r = 3'(n - ({3'b000, q} << 2) - {3'b000, q});
    return {q, r};
  endfunction

endpackage

### rtl/pis_cell.sv
// ----------------------------------------------------------------------------
// pis_cell: one state cell of a shift row
// Holds one value; loads the neighbor's value on shift and zeroes on clear.
// ----------------------------------------------------------------------------
module pis_cell #(
  parameter int W = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pis_pkg::cell_ctrl_t  ctrl_i,
  input  logic [W-1:0]         d_i,
  output logic [W-1:0]         q_o
);
  import pis_pkg::*;

  logic [W-1:0] value_q;
  logic [W-1:0] value_d;

  // Clear wins over shift, otherwise hold
  always_comb begin
    value_d = value_q;
    if (ctrl_i.clear) begin
      value_d = '0;
    end else if (ctrl_i.shift) begin
      value_d = d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign q_o = value_q;

endmodule

### rtl/pis_div5.sv
// ----------------------------------------------------------------------------
// pis_div5: two-stage rounding divide by five
// Computes round(v / 5), half toward plus infinity, as floor((v + 2) / 5)
// with base-16 digit steps, upper digits in the first stage, lower in the
// second. The result wraps to the output width.
// ----------------------------------------------------------------------------
module pis_div5 #(
  parameter int VW = 29
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [VW-1:0]             v_i,
  output logic signed [pis_pkg::OUT_W-1:0] y_o
);
  import pis_pkg::*;

  localparam int UW   = VW + 2;
  localparam int NDIG = (UW + 3) / 4;
  localparam int PW   = NDIG * 4;
  localparam int NHI  = (NDIG + 1) / 2;
  localparam int NLO  = NDIG - NHI;
  localparam int RW   = (PW + 1 > OUT_W) ? PW + 1 : OUT_W;
  localparam logic [PW-1:0] OFFSET = PW'(5) << (VW - 2);
  localparam logic [RW-1:0] BIAS   = RW'(1) << (VW - 2);

  logic [PW-1:0]       u;
  logic [PW-1:0]       qa;
  logic [2:0]          rem_a;
  logic [NHI*4-1:0]    qhi_q;
  logic [NLO*4-1:0]    lo_q;
  logic [2:0]          rem_q;
  logic [NLO*4-1:0]    qlo;
  logic [2:0]          rem_b;
  logic [PW-1:0]       q_full;
  logic signed [RW-1:0] y_wide;
  logic signed [OUT_W-1:0] y_q;
  logic [6:0]          step_a;
  logic [6:0]          step_b;

  // Offset the rounded numerator so it is never negative
  assign u = PW'(v_i) + PW'(2) + OFFSET;

  // Upper digits
  always_comb begin
    qa    = '0;
    rem_a = 3'd0;
    step_a = '0;
    for (int i = NDIG - 1; i >= NLO; i--) begin
      step_a         = div5_digit(rem_a, u[i*4 +: 4]);
      qa[i*4 +: 4]   = step_a[6:3];
      rem_a          = step_a[2:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qhi_q <= qa[PW-1 -: NHI*4];
      rem_q <= rem_a;
      lo_q  <= u[NLO*4-1:0];
    end
  end

  // Lower digits, then drop the offset
  always_comb begin
    qlo    = '0;
    rem_b  = rem_q;
    step_b = '0;
    for (int i = NLO - 1; i >= 0; i--) begin
      step_b        = div5_digit(rem_b, lo_q[i*4 +: 4]);
      qlo[i*4 +: 4] = step_b[6:3];
      rem_b         = step_b[2:0];
    end
    q_full = {qhi_q, qlo};
    y_wide = $signed(RW'(q_full) - BIAS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= y_wide[OUT_W-1:0];
    end
  end

  assign y_o = y_q;

endmodule

### rtl/powerline_interference_subtractor.sv
// ----------------------------------------------------------------------------
// powerline_interference_subtractor: mains hum removal for an ECG stream
// A word accepted at a clock edge passes the value register, the upper-digit
// divider register and the output register before it is offered. Throughput:
// one word per cycle while out_stall_i does not hold a full output register.
// Reset zeroes cells and sum; run counter to 1 and threshold to 3000.
// ----------------------------------------------------------------------------
module powerline_interference_subtractor #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic signed [SAMPLE_BITS-1:0]    sample_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [pis_pkg::OUT_W-1:0] sample_out_o,
  output logic                             template_updated_o,
  input  logic                             cfg_we_i,
  input  logic [pis_pkg::THR_W-1:0]        cfg_wdata_i
);
  import pis_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int VW = SB + 5;
  localparam int SW = SB + 3;
  localparam int CW = (SB + 1 > THR_W) ? SB + 1 : THR_W;

  logic signed [SB-1:0] tap [NTAP];
  logic signed [VW-1:0] ifr [PERIOD];
  logic signed [VW-1:0] ifr_tail_d;
  cell_ctrl_t           cell_ctrl;

  logic [THR_W-1:0]     thr_q;
  logic [2:0]           run_cnt_q, run_cnt_d;
  logic signed [SW-1:0] sum_q, sum_d;

  logic                 adv, acc, is_clear, filt, clr;
  logic signed [SB-1:0] x0, x1, x2, x5, x6;
  logic signed [SB:0]   diff_new, diff_old, hd, half;
  logic signed [SB+1:0] dcrit, dabs;
  logic [SB:0]          crit;
  logic                 linear, update;
  logic signed [VW-1:0] s_corr, x2x5, ifr_new, v0;

  logic                 vld1_q, upd1_q, vld2_q, upd2_q, out_valid_q, upd_out_q;
  logic signed [VW-1:0] v1_q;

  // Handshake: the whole pipe advances when the output register is empty or taken
  assign adv        = !out_valid_q || !out_stall_i;
  assign acc        = in_valid_i && adv;
  assign in_stall_o = !adv;
  assign is_clear   = (operation_i == OP_CLEAR);
  assign filt       = acc && !is_clear;
  assign clr        = acc && is_clear;
  assign cell_ctrl  = '{shift: filt, clear: clr};

  // Past samples: a row of cells, newest first
  for (genvar k = 0; k < NTAP; k++) begin : g_tap
    if (k == 0) begin : g_head
      pis_cell #(.W(SB)) u_cell (
        .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (cell_ctrl),
        .d_i (x0), .q_o (tap[k])
      );
    end else begin : g_body
      pis_cell #(.W(SB)) u_cell (
        .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (cell_ctrl),
        .d_i (tap[k-1]), .q_o (tap[k])
      );
    end
  end

  // Interference times five: a rotating row, head is the current phase
  for (genvar i = 0; i < PERIOD; i++) begin : g_ifr
    if (i == PERIOD - 1) begin : g_tail
      pis_cell #(.W(VW)) u_cell (
        .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (cell_ctrl),
        .d_i (ifr_tail_d), .q_o (ifr[i])
      );
    end else begin : g_body
      pis_cell #(.W(VW)) u_cell (
        .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (cell_ctrl),
        .d_i (ifr[i+1]), .q_o (ifr[i])
      );
    end
  end

  // Linearity test, corrected mean and interference update
  always_comb begin
    x0 = sample_in_i;
    x1 = tap[0];
    x2 = tap[1];
    x5 = tap[4];
    x6 = tap[5];

    diff_new = (SB+1)'(x5) - (SB+1)'(x0);
    diff_old = (SB+1)'(x6) - (SB+1)'(x1);
    dcrit    = (SB+2)'(diff_new) - (SB+2)'(diff_old);
    dabs     = dcrit[SB+1] ? -dcrit : dcrit;
    crit     = dabs[SB:0];
    linear   = CW'(crit) < CW'(thr_q);
    update   = linear && (run_cnt_q <= RUN_MIN);

    // Half step difference, truncated toward zero
    hd      = (SB+1)'(x0) - (SB+1)'(x5);
    half    = (hd >>> 1) + $signed((SB+1)'(hd[SB] & hd[0]));
    s_corr  = VW'(sum_q) - VW'(half);
    x2x5    = (VW'(x2) <<< 2) + VW'(x2);
    ifr_new = x2x5 - s_corr;
    v0      = update ? s_corr : (x2x5 - ifr[0]);

    ifr_tail_d = update ? ifr_new : ifr[0];
    sum_d      = sum_q + SW'(x0) - SW'(x5);

    run_cnt_d = run_cnt_q;
    if (!linear) begin
      run_cnt_d = RUN_MAX;
    end else if (run_cnt_q > RUN_MIN) begin
      run_cnt_d = run_cnt_q - 3'd1;
    end else begin
      run_cnt_d = RUN_MIN;
    end
  end

  // Threshold, run counter, running sum and pipe control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THR_RESET;
      run_cnt_q   <= RUN_MIN;
      sum_q       <= '0;
      vld1_q      <= 1'b0;
      upd1_q      <= 1'b0;
      vld2_q      <= 1'b0;
      upd2_q      <= 1'b0;
      out_valid_q <= 1'b0;
      upd_out_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (clr) begin
        run_cnt_q <= RUN_MIN;
        sum_q     <= '0;
      end else if (filt) begin
        run_cnt_q <= run_cnt_d;
        sum_q     <= sum_d;
      end
      if (adv) begin
        vld1_q      <= acc;
        upd1_q      <= filt && update;
        vld2_q      <= vld1_q;
        upd2_q      <= upd1_q;
        out_valid_q <= vld2_q;
        upd_out_q   <= upd2_q;
      end
    end
  end

  // Hold the unrounded value for the divider
  always_ff @(posedge clk_i) begin
    if (adv) begin
      v1_q <= filt ? v0 : '0;
    end
  end

  pis_div5 #(.VW(VW)) u_div5 (
    .clk_i (clk_i),
    .en_i  (adv),
    .v_i   (v1_q),
    .y_o   (sample_out_o)
  );

  assign out_valid_o        = out_valid_q;
  assign template_updated_o = upd_out_q;

  // Running sum always matches the five newest past samples
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q == SW'(tap[0]) + SW'(tap[1]) + SW'(tap[2]) + SW'(tap[3]) + SW'(tap[4]))
    else $error("running sum out of step with sample cells");

  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_cnt_q >= RUN_MIN && run_cnt_q <= RUN_MAX)
    else $error("run counter out of range");

  a_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !template_updated_o)
    else $error("update flag set on an empty output");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> (tap[0] == '0 && ifr[0] == '0 && run_cnt_q == RUN_MIN))
    else $error("clear did not reset the cell rows");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the output is empty");

endmodule
